@@ src/servo_position_pid_with_manual_mode_top_defines.svh @@
// Assertion macros shared by the checker of the servo position controller.
`ifndef SERVO_POSITION_PID_WITH_MANUAL_MODE_TOP_DEFINES_SVH
`define SERVO_POSITION_PID_WITH_MANUAL_MODE_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPID_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("spid checker: property failed");

// The consequent must hold in the cycle after the antecedent.
`define SPID_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("spid checker: property failed");

`endif

@@ src/spid_pkg.sv @@
// Types and constants shared by the servo position controller modules.
package spid_pkg;

    typedef enum logic [2:0] {
        REQ_SAMPLE      = 3'd0,
        REQ_MANUAL_STOP = 3'd1,
        REQ_PID_MODE    = 3'd2,
        REQ_FORWARD     = 3'd3,
        REQ_REVERSE     = 3'd4,
        REQ_OFFSET_UP   = 3'd5,
        REQ_OFFSET_DOWN = 3'd6,
        REQ_CTRL_RESET  = 3'd7
    } t_req;

    typedef enum logic [2:0] {
        REG_TARGET         = 3'd0,
        REG_STOP_TOLERANCE = 3'd1,
        REG_GAIN_P         = 3'd2,
        REG_GAIN_I         = 3'd3,
        REG_GAIN_D         = 3'd4,
        REG_INTEGRAL_LIMIT = 3'd5,
        REG_MAX_OFFSET     = 3'd6,
        REG_MIN_MOVING     = 3'd7
    } t_reg_idx;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic signed [30:0] target_counts;
        logic [11:0]        stop_tolerance;
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic [30:0]        integral_limit;
        logic [9:0]         max_offset_us;
        logic [9:0]         min_moving_us;
    } t_cfg;

    localparam int MUL_STEPS   = 32;
    localparam int DIV_STEPS   = 64;
    localparam int SCALE_DEN   = 256000;
    localparam int P_SCALE     = 1000;
    localparam int D_SCALE     = 1000000;
    localparam int OFFSET_STEP = 10;

    localparam logic [63:0] ALU_CAP = 64'h0000_0400_0000_0000;
    localparam logic [63:0] ALU_BIG = 64'h0000_0100_0000_0000;

endpackage

@@ src/spid_cfg_regs.sv @@
// Configuration register file with its APB-style access port.
module spid_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [4:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output spid_pkg::t_cfg o_cfg
);
    import spid_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_counts  <= 31'sd1024;
            r_cfg.stop_tolerance <= 12'd1;
            r_cfg.gain_p         <= '0;
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.integral_limit <= '0;
            r_cfg.max_offset_us  <= '0;
            r_cfg.min_moving_us  <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_TARGET:         r_cfg.target_counts  <= $signed(pwdata[30:0]);
                REG_STOP_TOLERANCE: r_cfg.stop_tolerance <= pwdata[11:0];
                REG_GAIN_P:         r_cfg.gain_p         <= $signed(pwdata[15:0]);
                REG_GAIN_I:         r_cfg.gain_i         <= $signed(pwdata[15:0]);
                REG_GAIN_D:         r_cfg.gain_d         <= $signed(pwdata[15:0]);
                REG_INTEGRAL_LIMIT: r_cfg.integral_limit <= pwdata[30:0];
                REG_MAX_OFFSET:     r_cfg.max_offset_us  <= pwdata[9:0];
                REG_MIN_MOVING:     r_cfg.min_moving_us  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TARGET:         prdata = {r_cfg.target_counts[30], r_cfg.target_counts};
            REG_STOP_TOLERANCE: prdata = {20'd0, r_cfg.stop_tolerance};
            REG_GAIN_P:         prdata = {{16{r_cfg.gain_p[15]}}, r_cfg.gain_p};
            REG_GAIN_I:         prdata = {{16{r_cfg.gain_i[15]}}, r_cfg.gain_i};
            REG_GAIN_D:         prdata = {{16{r_cfg.gain_d[15]}}, r_cfg.gain_d};
            REG_INTEGRAL_LIMIT: prdata = {1'b0, r_cfg.integral_limit};
            REG_MAX_OFFSET:     prdata = {22'd0, r_cfg.max_offset_us};
            REG_MIN_MOVING:     prdata = {22'd0, r_cfg.min_moving_us};
            default:            prdata = '0;
        endcase
    end

endmodule

@@ src/spid_serial_alu.sv @@
// Bit-serial unsigned shift-add multiplier and restoring divider.
module spid_serial_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spid_pkg::t_alu_req i_req,
    input  logic [63:0]        i_a,
    input  logic [31:0]        i_b,
    output logic               o_done,
    output logic [63:0]        o_result
);
    import spid_pkg::*;

    logic [63:0] r_a;
    logic [31:0] r_b;
    logic [63:0] r_acc;
    logic [31:0] r_rem;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    t_alu_op     r_op;

    logic [32:0] w_rem_sh;
    logic [32:0] w_rem_sub;
    logic        w_ge;

    assign w_rem_sh  = {r_rem, r_a[63]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_b});
    assign w_rem_sub = w_rem_sh - {1'b0, r_b};
    assign o_done    = r_done;
    assign o_result  = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == 7'd0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_req.op == ALU_MUL) ? 7'(MUL_STEPS - 1) : 7'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_rem <= '0;
            r_op  <= i_req.op;
        end else if (r_busy) begin
            r_a <= {r_a[62:0], 1'b0};
            if (r_op == ALU_MUL) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_b <= {1'b0, r_b[31:1]};
            end else begin
                r_rem <= w_ge ? w_rem_sub[31:0] : w_rem_sh[31:0];
                r_acc <= {r_acc[62:0], w_ge};
            end
        end
    end

endmodule

@@ src/servo_position_pid_with_manual_mode_top.sv @@
// Servo position controller top level: sequencer, controller state and stream ports.
// Commands and samples that run no PID step go from S_EVAL to S_OUT, which offers the
// result once the output is free. A sample that runs a PID step uses the bit-serial unit
// for up to six products and two quotients. One item at a time: the next transfer in is
// taken only back in S_IDLE, which follows S_OUT once the result has been offered.
// Reset is synchronous and active low; it restores all control and controller state at once.
module servo_position_pid_with_manual_mode_top #(
    parameter int STOP_PULSE_US       = 1500,
    parameter int MANUAL_OFFSET_RESET = 100,
    parameter int DEFAULT_DT_MS       = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // position_counts[30:0], magnet_ok[31], now_ms[63:32]
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // pulse_width[11:0], pid_offset_us[22:12], error_counts[54:23],
                                   // stopped[55], pid_active[56], zeros[63:57]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import spid_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE      = 14'h0001,
        S_EVAL      = 14'h0002,
        S_INT_MUL   = 14'h0004,
        S_INT_CLAMP = 14'h0008,
        S_P_MUL1    = 14'h0010,
        S_P_MUL2    = 14'h0020,
        S_I_MUL     = 14'h0040,
        S_D_MUL1    = 14'h0080,
        S_D_MUL2    = 14'h0100,
        S_D_DIV     = 14'h0200,
        S_LIMIT     = 14'h0400,
        S_PUSH      = 14'h0800,
        S_Q_DIV     = 14'h1000,
        S_OUT       = 14'h2000
    } t_state;

    t_state r_state, n_state;

    t_cfg        w_cfg;
    t_alu_req    w_alu_req;
    logic [63:0] w_alu_a;
    logic [31:0] w_alu_b;
    logic        w_alu_done;
    logic [63:0] w_alu_res;

    t_req               r_req;
    logic signed [30:0] r_pos;
    logic               r_mag;
    logic [31:0]        r_now;
    logic signed [31:0] r_err;
    logic [31:0]        r_dt;
    logic signed [42:0] r_isum;
    logic signed [63:0] r_nsum;
    logic signed [63:0] r_n;
    logic               r_n_neg;

    logic               r_pid_mode;
    logic [11:0]        r_pulse;
    logic [9:0]         r_manual_off;
    logic               r_stopped;
    logic               r_have_prev;
    logic signed [31:0] r_prev_err;
    logic signed [31:0] r_integral;
    logic [31:0]        r_prev_time;
    logic signed [10:0] r_last_off;
    logic               r_out_valid;
    logic [63:0]        r_out_data;

    logic signed [31:0] w_err;
    logic [31:0]        w_aerr;
    logic               w_stop;
    logic               w_move;
    logic [31:0]        w_dt;
    logic               w_clear;
    logic [31:0]        w_err_mag;
    logic [31:0]        w_int_mag;
    logic [15:0]        w_gp_mag;
    logic [15:0]        w_gi_mag;
    logic [15:0]        w_gd_mag;
    logic signed [32:0] w_diff;
    logic [32:0]        w_diff_mag;
    logic               w_sign_p;
    logic               w_sign_i;
    logic               w_sign_d;
    logic [40:0]        w_step_mag;
    logic signed [42:0] w_step;
    logic signed [42:0] w_isum_next;
    logic signed [42:0] w_int_lim;
    logic signed [42:0] w_int_lim_neg;
    logic signed [31:0] w_int_clamped;
    logic signed [63:0] w_res_pos;
    logic signed [63:0] w_res_neg;
    logic signed [63:0] w_big_term;
    logic [27:0]        w_lim_mag;
    logic [27:0]        w_mn_mag;
    logic signed [63:0] w_lim;
    logic signed [63:0] w_mn;
    logic signed [63:0] w_push;
    logic [63:0]        w_push_mag;
    logic [10:0]        w_q;
    logic signed [10:0] w_off;
    logic [10:0]        w_up_sum;
    logic [10:0]        w_dn_diff;
    logic [9:0]         w_off_up;
    logic [9:0]         w_off_down;
    logic               w_out_free;

    spid_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    spid_serial_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_alu_req),
        .i_a      (w_alu_a),
        .i_b      (w_alu_b),
        .o_done   (w_alu_done),
        .o_result (w_alu_res)
    );

    assign s_tready   = (r_state == S_IDLE);
    assign m_tvalid   = r_out_valid;
    assign m_tdata    = r_out_data;
    assign w_out_free = !r_out_valid || m_tready;

    assign w_err  = $signed({w_cfg.target_counts[30], w_cfg.target_counts})
                  - $signed({r_pos[30], r_pos});
    assign w_aerr = w_err[31] ? 32'(-w_err) : 32'(w_err);
    assign w_stop = !r_mag || (w_aerr <= {20'd0, w_cfg.stop_tolerance});
    assign w_move = (r_req == REQ_SAMPLE) && r_pid_mode && !w_stop;
    assign w_dt   = ((r_prev_time != 32'd0) && (r_now > r_prev_time))
                  ? (r_now - r_prev_time) : 32'(DEFAULT_DT_MS);

    assign w_err_mag = r_err[31] ? 32'(-r_err) : 32'(r_err);
    assign w_int_mag = r_integral[31] ? 32'(-r_integral) : 32'(r_integral);
    assign w_gp_mag  = w_cfg.gain_p[15] ? 16'(-w_cfg.gain_p) : 16'(w_cfg.gain_p);
    assign w_gi_mag  = w_cfg.gain_i[15] ? 16'(-w_cfg.gain_i) : 16'(w_cfg.gain_i);
    assign w_gd_mag  = w_cfg.gain_d[15] ? 16'(-w_cfg.gain_d) : 16'(w_cfg.gain_d);

    assign w_diff     = $signed({r_err[31], r_err}) - $signed({r_prev_err[31], r_prev_err});
    assign w_diff_mag = w_diff[32] ? 33'(-w_diff) : 33'(w_diff);
    assign w_sign_p   = w_cfg.gain_p[15] ^ r_err[31];
    assign w_sign_i   = w_cfg.gain_i[15] ^ r_integral[31];
    assign w_sign_d   = w_cfg.gain_d[15] ^ w_diff[32];

    assign w_step_mag    = (w_alu_res > ALU_BIG) ? ALU_BIG[40:0] : w_alu_res[40:0];
    assign w_step        = r_err[31] ? -$signed({2'b00, w_step_mag}) : $signed({2'b00, w_step_mag});
    assign w_isum_next   = $signed({{11{r_integral[31]}}, r_integral}) + w_step;
    assign w_int_lim     = $signed({12'd0, w_cfg.integral_limit});
    assign w_int_lim_neg = -w_int_lim;
    assign w_int_clamped = (r_isum > w_int_lim) ? w_int_lim[31:0]
                         : (r_isum < w_int_lim_neg) ? w_int_lim_neg[31:0] : r_isum[31:0];

    assign w_res_pos  = $signed(w_alu_res);
    assign w_res_neg  = -$signed(w_alu_res);
    assign w_big_term = w_sign_d ? -$signed(ALU_BIG) : $signed(ALU_BIG);

    assign w_lim_mag  = 28'(w_cfg.max_offset_us) * 28'(SCALE_DEN);
    assign w_mn_mag   = 28'(w_cfg.min_moving_us) * 28'(SCALE_DEN);
    assign w_lim      = $signed({36'd0, w_lim_mag});
    assign w_mn       = $signed({36'd0, w_mn_mag});
    assign w_push     = ((r_n > 64'sd0) && (r_n < w_mn)) ? w_mn
                      : ((r_n < 64'sd0) && (r_n > -w_mn)) ? -w_mn : r_n;
    assign w_push_mag = w_push[63] ? 64'(-w_push) : 64'(w_push);

    assign w_q   = w_alu_res[10:0];
    assign w_off = r_n_neg ? $signed(-w_q) : $signed(w_q);

    assign w_up_sum   = {1'b0, r_manual_off} + 11'(OFFSET_STEP);
    assign w_dn_diff  = {1'b0, r_manual_off} - 11'(OFFSET_STEP);
    assign w_off_up   = (w_up_sum > {1'b0, w_cfg.max_offset_us})
                      ? w_cfg.max_offset_us : w_up_sum[9:0];
    assign w_off_down = w_dn_diff[10] ? 10'd0
                      : ((w_dn_diff[9:0] > w_cfg.max_offset_us)
                         ? w_cfg.max_offset_us : w_dn_diff[9:0]);

    always_comb begin
        w_clear = 1'b0;
        if (r_state == S_EVAL) begin
            case (r_req)
                REQ_SAMPLE:      w_clear = !r_pid_mode || w_stop;
                REQ_MANUAL_STOP: w_clear = r_pid_mode;
                REQ_FORWARD:     w_clear = r_pid_mode;
                REQ_REVERSE:     w_clear = r_pid_mode;
                REQ_PID_MODE:    w_clear = !r_pid_mode;
                REQ_CTRL_RESET:  w_clear = 1'b1;
                default:         w_clear = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_state         = r_state;
        w_alu_req.start = 1'b0;
        w_alu_req.op    = ALU_MUL;
        w_alu_a         = '0;
        w_alu_b         = '0;
        case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (w_move) begin
                    w_alu_req.start = 1'b1;
                    w_alu_a         = {32'd0, w_aerr};
                    w_alu_b         = w_dt;
                    n_state         = S_INT_MUL;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_INT_MUL: begin
                if (w_alu_done) begin
                    n_state = S_INT_CLAMP;
                end
            end
            S_INT_CLAMP: begin
                w_alu_req.start = 1'b1;
                w_alu_a         = {32'd0, w_err_mag};
                w_alu_b         = {16'd0, w_gp_mag};
                n_state         = S_P_MUL1;
            end
            S_P_MUL1: begin
                if (w_alu_done) begin
                    w_alu_req.start = 1'b1;
                    w_alu_a         = w_alu_res;
                    w_alu_b         = 32'(P_SCALE);
                    n_state         = S_P_MUL2;
                end
            end
            S_P_MUL2: begin
                if (w_alu_done) begin
                    w_alu_req.start = 1'b1;
                    w_alu_a         = {32'd0, w_int_mag};
                    w_alu_b         = {16'd0, w_gi_mag};
                    n_state         = S_I_MUL;
                end
            end
            S_I_MUL: begin
                if (w_alu_done) begin
                    if (r_have_prev) begin
                        w_alu_req.start = 1'b1;
                        w_alu_a         = {31'd0, w_diff_mag};
                        w_alu_b         = {16'd0, w_gd_mag};
                        n_state         = S_D_MUL1;
                    end else begin
                        n_state = S_LIMIT;
                    end
                end
            end
            S_D_MUL1: begin
                if (w_alu_done) begin
                    if (w_alu_res > ALU_CAP) begin
                        n_state = S_LIMIT;
                    end else begin
                        w_alu_req.start = 1'b1;
                        w_alu_a         = w_alu_res;
                        w_alu_b         = 32'(D_SCALE);
                        n_state         = S_D_MUL2;
                    end
                end
            end
            S_D_MUL2: begin
                if (w_alu_done) begin
                    w_alu_req.start = 1'b1;
                    w_alu_req.op    = ALU_DIV;
                    w_alu_a         = w_alu_res;
                    w_alu_b         = r_dt;
                    n_state         = S_D_DIV;
                end
            end
            S_D_DIV: begin
                if (w_alu_done) begin
                    n_state = S_LIMIT;
                end
            end
            S_LIMIT: begin
                n_state = S_PUSH;
            end
            S_PUSH: begin
                w_alu_req.start = 1'b1;
                w_alu_req.op    = ALU_DIV;
                w_alu_a         = w_push_mag;
                w_alu_b         = 32'(SCALE_DEN);
                n_state         = S_Q_DIV;
            end
            S_Q_DIV: begin
                if (w_alu_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pid_mode   <= 1'b0;
            r_pulse      <= 12'(STOP_PULSE_US);
            r_manual_off <= 10'(MANUAL_OFFSET_RESET);
            r_stopped    <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_EVAL: begin
                    case (r_req)
                        REQ_SAMPLE: begin
                            if (!r_pid_mode) begin
                                r_stopped <= (r_pulse == 12'(STOP_PULSE_US));
                            end else if (w_stop) begin
                                r_stopped <= 1'b1;
                                r_pulse   <= 12'(STOP_PULSE_US);
                            end else begin
                                r_stopped <= 1'b0;
                            end
                        end
                        REQ_MANUAL_STOP: begin
                            r_pid_mode <= 1'b0;
                            r_pulse    <= 12'(STOP_PULSE_US);
                            r_stopped  <= 1'b1;
                        end
                        REQ_PID_MODE: begin
                            r_pid_mode <= 1'b1;
                        end
                        REQ_FORWARD: begin
                            r_pid_mode <= 1'b0;
                            r_pulse    <= 12'(STOP_PULSE_US) + {2'b00, r_manual_off};
                            r_stopped  <= 1'b0;
                        end
                        REQ_REVERSE: begin
                            r_pid_mode <= 1'b0;
                            r_pulse    <= 12'(STOP_PULSE_US) - {2'b00, r_manual_off};
                            r_stopped  <= 1'b0;
                        end
                        REQ_OFFSET_UP: begin
                            r_manual_off <= w_off_up;
                        end
                        REQ_OFFSET_DOWN: begin
                            r_manual_off <= w_off_down;
                        end
                        default: ;
                    endcase
                end
                S_Q_DIV: begin
                    if (w_alu_done) begin
                        r_pulse <= 12'(STOP_PULSE_US) + {w_off[10], w_off};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev_err  <= '0;
            r_integral  <= '0;
            r_prev_time <= '0;
            r_last_off  <= '0;
        end else if (w_clear) begin
            r_have_prev <= 1'b0;
            r_prev_err  <= '0;
            r_integral  <= '0;
            r_prev_time <= '0;
            r_last_off  <= '0;
        end else begin
            if ((r_state == S_EVAL) && w_move) begin
                r_prev_time <= r_now;
            end
            if (r_state == S_INT_CLAMP) begin
                r_integral <= w_int_clamped;
            end
            if ((r_state == S_Q_DIV) && w_alu_done) begin
                r_last_off  <= w_off;
                r_have_prev <= 1'b1;
                r_prev_err  <= r_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_req <= t_req'(s_tuser);
            r_pos <= $signed(s_tdata[30:0]);
            r_mag <= s_tdata[31];
            r_now <= s_tdata[63:32];
        end
        case (r_state)
            S_EVAL: begin
                r_err <= (r_req == REQ_SAMPLE) ? w_err : 32'sd0;
                r_dt  <= w_dt;
            end
            S_INT_MUL: begin
                if (w_alu_done) begin
                    r_isum <= w_isum_next;
                end
            end
            S_P_MUL2: begin
                if (w_alu_done) begin
                    r_nsum <= w_sign_p ? w_res_neg : w_res_pos;
                end
            end
            S_I_MUL: begin
                if (w_alu_done) begin
                    r_nsum <= r_nsum + (w_sign_i ? w_res_neg : w_res_pos);
                end
            end
            S_D_MUL1: begin
                if (w_alu_done && (w_alu_res > ALU_CAP)) begin
                    r_nsum <= r_nsum + w_big_term;
                end
            end
            S_D_DIV: begin
                if (w_alu_done) begin
                    r_nsum <= r_nsum + (w_sign_d ? w_res_neg : w_res_pos);
                end
            end
            S_LIMIT: begin
                r_n <= (r_nsum > w_lim) ? w_lim : ((r_nsum < -w_lim) ? -w_lim : r_nsum);
            end
            S_PUSH: begin
                r_n_neg <= w_push[63];
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_out_data <= {7'd0, r_pid_mode, r_stopped, r_err, r_last_off, r_pulse};
                end
            end
            default: ;
        endcase
    end

endmodule

@@ src/spid_checker.sv @@
// Port-level checker for the servo position controller and its bind statement.
`include "servo_position_pid_with_manual_mode_top_defines.svh"

module spid_checker #(
    parameter int STOP_PULSE_US = 1500
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    // A stalled result stays offered until it is taken.
    `SPID_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid)

    // Only one item is in work at a time.
    `SPID_ASSERT_NXT(a_one_item, i_clk, i_rst_n, s_tvalid && s_tready, !s_tready)

    // In manual mode the PID offset has always been cleared.
    `SPID_ASSERT_IMP(a_manual_offset, i_clk, i_rst_n, m_tvalid && !m_tdata[56], m_tdata[22:12] == 11'd0)

    // A servo reported as stopped is driven with the stop pulse.
    `SPID_ASSERT_IMP(a_stop_pulse, i_clk, i_rst_n, m_tvalid && m_tdata[55], m_tdata[11:0] == 12'(STOP_PULSE_US))

endmodule

bind servo_position_pid_with_manual_mode_top spid_checker #(
    .STOP_PULSE_US (STOP_PULSE_US)
) u_spid_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
